// ----- hdl/bis_pkg.sv -----
// Shared types and constants for the burner ignition sequencer.
`default_nettype none
package bis_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 12;
  localparam int TICK_W   = 16;
  localparam int SERVO_W  = 8;
  localparam int STATUS_W = 2;
  localparam int PHASE_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IGNITE_TICKS    = 2'd0,
    REG_RETRY_TICKS     = 2'd1,
    REG_STABILIZE_TICKS = 2'd2,
    REG_FLAME_THRESHOLD = 2'd3
  } cfg_reg_t;

  // Register reset values.
  localparam logic [TICK_W-1:0]   IGNITE_TICKS_RST    = 16'd2000;
  localparam logic [TICK_W-1:0]   RETRY_TICKS_RST     = 16'd10000;
  localparam logic [TICK_W-1:0]   STABILIZE_TICKS_RST = 16'd2000;
  localparam logic [SAMPLE_W-1:0] FLAME_THRESHOLD_RST = 12'd10;

  // Servo angles in degrees.
  localparam logic [SERVO_W-1:0] SERVO_OPEN = 8'd180;
  localparam logic [SERVO_W-1:0] SERVO_LOW  = 8'd45;
  localparam logic [SERVO_W-1:0] SERVO_HIGH = 8'd90;

  // Status codes shown on the result.
  localparam logic [STATUS_W-1:0] STAT_OFF   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IGN   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RETRY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RUN   = 2'd3;

  // Phase codes shown on the result.
  localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_CODE_IGNITE = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_CODE_RETRY  = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_CODE_STAB   = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_CODE_RUN    = 3'd4;

  // Configuration register set.
  typedef struct packed {
    logic [TICK_W-1:0]   ignite_ticks;
    logic [TICK_W-1:0]   retry_ticks;
    logic [TICK_W-1:0]   stabilize_ticks;
    logic [SAMPLE_W-1:0] flame_threshold;
  } bis_cfg_t;

  // One input item.
  typedef struct packed {
    logic                call_for_heat;
    logic [SAMPLE_W-1:0] flame_sample;
    logic [SAMPLE_W-1:0] room_temp;
    logic [SAMPLE_W-1:0] target_temp;
  } bis_in_t;

  // One result item.
  typedef struct packed {
    logic                ignitor_on;
    logic                valve_on;
    logic [SERVO_W-1:0]  servo_angle;
    logic [STATUS_W-1:0] status_code;
    logic [PHASE_W-1:0]  phase;
  } bis_out_t;

endpackage
`default_nettype wire

// ----- hdl/bis_cfg_regs.sv -----
// Configuration register file of the burner ignition sequencer.
`default_nettype none
module bis_cfg_regs
  import bis_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output bis_cfg_t                   cfg_o
);

  bis_cfg_t cfg_r;

  // Decode the register index and store the masked write data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ignite_ticks    <= IGNITE_TICKS_RST;
      cfg_r.retry_ticks     <= RETRY_TICKS_RST;
      cfg_r.stabilize_ticks <= STABILIZE_TICKS_RST;
      cfg_r.flame_threshold <= FLAME_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_IGNITE_TICKS:    cfg_r.ignite_ticks    <= cfg_wdata[TICK_W-1:0];
        REG_RETRY_TICKS:     cfg_r.retry_ticks     <= cfg_wdata[TICK_W-1:0];
        REG_STABILIZE_TICKS: cfg_r.stabilize_ticks <= cfg_wdata[TICK_W-1:0];
        REG_FLAME_THRESHOLD: cfg_r.flame_threshold <= cfg_wdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule
`default_nettype wire

// ----- hdl/bis_in_reg.sv -----
// Input register stage that holds one accepted item for the sequencer core.
`default_nettype none
module bis_in_reg
  import bis_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  bis_in_t      in_data,
  output logic         item_vld_o,
  output bis_in_t      item_o,
  input  wire logic    item_take_i
);

  logic    vld_r;
  bis_in_t data_r;

  // The stage is free when empty or when the core takes its item this cycle.
  assign in_stall = vld_r && !item_take_i;

  // Valid flag of the held item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  // Item payload, loaded only on acceptance.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_data;
    end
  end

  assign item_vld_o = vld_r;
  assign item_o     = data_r;

endmodule
`default_nettype wire

// ----- hdl/bis_core.sv -----
// Ignition sequencer state machine with its result register.
`default_nettype none
module bis_core
  import bis_pkg::*;
#(
  parameter int CMP_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  bis_cfg_t  cfg_i,
  input  wire logic item_vld_i,
  input  bis_in_t   item_i,
  output logic      item_take_o,
  output logic      out_valid,
  input  wire logic out_stall,
  output bis_out_t  out_data
);

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_IGNITE = 3'd1,
    PH_RETRY  = 3'd2,
    PH_STAB   = 3'd3,
    PH_RUN    = 3'd4
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt, tick_inc;
  logic [SERVO_W-1:0]  servo_r, servo_nxt;
  logic                out_vld_r;
  bis_out_t            out_r, out_nxt;
  logic [CMP_BITS-1:0] flame_cmp, thr_cmp, room_cmp, target_cmp;
  logic                flame_ok;

  // The held item moves on when the result register is empty or being drained.
  assign item_take_o = item_vld_i && (!out_vld_r || !out_stall);

  // Samples and threshold are compared on the configured sample width.
  assign flame_cmp  = item_i.flame_sample[CMP_BITS-1:0];
  assign thr_cmp    = cfg_i.flame_threshold[CMP_BITS-1:0];
  assign room_cmp   = item_i.room_temp[CMP_BITS-1:0];
  assign target_cmp = item_i.target_temp[CMP_BITS-1:0];
  assign flame_ok   = flame_cmp > thr_cmp;
  assign tick_inc   = tick_r + 16'd1;

  // Next phase, tick count and servo command for the held item.
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    servo_nxt = servo_r;
    unique case (phase_r)
      PH_IGNITE: begin
        tick_nxt = tick_inc;
        if (tick_inc >= cfg_i.ignite_ticks) begin
          tick_nxt = '0;
          if (flame_ok) begin
            servo_nxt = SERVO_OPEN;
            phase_nxt = PH_STAB;
          end else begin
            phase_nxt = PH_RETRY;
          end
        end
      end
      PH_RETRY: begin
        tick_nxt = tick_inc;
        if (tick_inc >= cfg_i.retry_ticks) begin
          tick_nxt  = '0;
          phase_nxt = PH_IGNITE;
        end
      end
      PH_STAB: begin
        tick_nxt = tick_inc;
        if (tick_inc >= cfg_i.stabilize_ticks) begin
          tick_nxt  = '0;
          phase_nxt = PH_RUN;
        end
      end
      PH_RUN: begin
        if (item_i.call_for_heat) begin
          servo_nxt = (room_cmp < target_cmp) ? SERVO_LOW : SERVO_HIGH;
        end else begin
          tick_nxt  = '0;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (item_i.call_for_heat) begin
          tick_nxt  = '0;
          phase_nxt = PH_IGNITE;
        end
      end
    endcase
  end

  // Result fields follow the phase after this item's update.
  always_comb begin
    out_nxt.ignitor_on  = 1'b0;
    out_nxt.valve_on    = 1'b0;
    out_nxt.servo_angle = servo_nxt;
    out_nxt.status_code = STAT_OFF;
    out_nxt.phase       = PHASE_CODE_IDLE;
    unique case (phase_nxt)
      PH_IGNITE: begin
        out_nxt.ignitor_on  = 1'b1;
        out_nxt.valve_on    = 1'b1;
        out_nxt.status_code = STAT_IGN;
        out_nxt.phase       = PHASE_CODE_IGNITE;
      end
      PH_RETRY: begin
        out_nxt.status_code = STAT_RETRY;
        out_nxt.phase       = PHASE_CODE_RETRY;
      end
      PH_STAB: begin
        out_nxt.ignitor_on  = 1'b1;
        out_nxt.valve_on    = 1'b1;
        out_nxt.status_code = STAT_IGN;
        out_nxt.phase       = PHASE_CODE_STAB;
      end
      PH_RUN: begin
        out_nxt.status_code = STAT_RUN;
        out_nxt.phase       = PHASE_CODE_RUN;
      end
      default: ;
    endcase
  end

  // State moves when an item is taken; result valid also drops when drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      servo_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (item_take_o) begin
        phase_r   <= phase_nxt;
        tick_r    <= tick_nxt;
        servo_r   <= servo_nxt;
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (item_take_o) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- hdl/burner_ignition_sequencer_top.sv -----
// Top level of the gas burner ignition sequencer with flame proving.
//
// Each input item is one timer tick and yields exactly one result item that
// shows the ignitor, pilot valve, servo angle, status and phase after that
// tick. The block takes one item per clock cycle while out_stall is low: an
// input register feeds a combinational next-state update, whose result lands
// in an output register when the core takes the item from the input register,
// and a new item can still be accepted while an earlier result waits. The
// sequencer state advances only as items are processed, so the timed phases
// count items, not clock cycles. Configuration registers are written through
// cfg_we, cfg_idx and cfg_wdata; the user must write them only while no item
// is in flight, which the block itself does not enforce. SAMPLE_BITS sets
// how many low bits (at most 12) of samples and flame threshold are compared.
`default_nettype none
module burner_ignition_sequencer_top
  import bis_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  bis_in_t                    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output bis_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Samples are 12 bits wide, so no more than that can take part in a compare.
  localparam int CMP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  bis_cfg_t cfg;
  logic     item_vld;
  bis_in_t  item;
  logic     item_take;

  // Configuration registers.
  bis_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Input register.
  bis_in_reg u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .item_vld_o  (item_vld),
    .item_o      (item),
    .item_take_i (item_take)
  );

  // Sequencer and result register.
  bis_core #(
    .CMP_BITS (CMP_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg),
    .item_vld_i  (item_vld),
    .item_i      (item),
    .item_take_o (item_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // Ignitor and pilot valve always switch together.
  a_ign_valve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ignitor_on == out_data.valve_on))
    else $error("ignitor and valve disagree");

  // Run phase always reports the running status and a closed ignitor.
  a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.phase == PHASE_CODE_RUN) |->
      (out_data.status_code == STAT_RUN && !out_data.ignitor_on))
    else $error("run phase with wrong status");

  // Stabilize phase always has the servo fully open.
  a_stab_servo: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.phase == PHASE_CODE_STAB) |->
      (out_data.servo_angle == SERVO_OPEN))
    else $error("stabilize phase without open servo");

  // An item accepted while the input stage is empty fills that stage.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !item_vld) |=> item_vld)
    else $error("accepted item lost");

endmodule
`default_nettype wire
